>>> rtl/slsg_pkg.sv
// Shared types and constants for the stall load speed governor.
// Holds the period and load curve tables, register indexes and fixed-point constants.
// No dependencies.
`default_nettype none

package slsg_pkg;

  localparam int TABLE_CAP = 64;

  localparam int PERIOD_W = 24;
  localparam int LOAD_W   = 10;
  localparam int CFG_W    = 24;
  localparam int GUARD_W  = 5;

  // reciprocal of ten for 24-bit dividends, exact with a 28-bit shift
  localparam int RECIP10_SHIFT = 28;
  localparam logic [24:0] RECIP10 = 25'd26843546;

  typedef enum logic [2:0] {
    CFG_GUARD_TICKS      = 3'd0,
    CFG_THRESHOLD_SLOPE  = 3'd1,
    CFG_THRESHOLD_OFFSET = 3'd2,
    CFG_MAX_PERIOD       = 3'd3,
    CFG_MIN_PERIOD       = 3'd4
  } cfg_index_t;

  localparam logic [4:0]  RST_GUARD_TICKS      = 5'd25;
  localparam logic [15:0] RST_THRESHOLD_SLOPE  = 16'd12730;
  localparam logic [23:0] RST_THRESHOLD_OFFSET = 24'd2554508;
  localparam logic [15:0] RST_MAX_PERIOD       = 16'd3619;
  localparam logic [15:0] RST_MIN_PERIOD       = 16'd90;

  localparam logic [15:0] PERIOD_ROM [TABLE_CAP] = '{
    16'd3619, 16'd1809, 16'd1206, 16'd904, 16'd723, 16'd603, 16'd517, 16'd452,
    16'd402, 16'd361, 16'd329, 16'd301, 16'd278, 16'd258, 16'd241, 16'd226,
    16'd212, 16'd201, 16'd190, 16'd180, 16'd172, 16'd164, 16'd157, 16'd150,
    16'd144, 16'd139, 16'd134, 16'd129, 16'd124, 16'd120, 16'd116, 16'd113,
    16'd109, 16'd106, 16'd103, 16'd100, 16'd97, 16'd95, 16'd92, 16'd90,
    16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
    16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
    16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0
  };

  // period table shifted by one entry: the lower edge of each bracket
  localparam logic [15:0] PERIOD_NEXT [TABLE_CAP] = '{
    16'd1809, 16'd1206, 16'd904, 16'd723, 16'd603, 16'd517, 16'd452, 16'd402,
    16'd361, 16'd329, 16'd301, 16'd278, 16'd258, 16'd241, 16'd226, 16'd212,
    16'd201, 16'd190, 16'd180, 16'd172, 16'd164, 16'd157, 16'd150, 16'd144,
    16'd139, 16'd134, 16'd129, 16'd124, 16'd120, 16'd116, 16'd113, 16'd109,
    16'd106, 16'd103, 16'd100, 16'd97, 16'd95, 16'd92, 16'd90, 16'd0,
    16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
    16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
    16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0
  };

  localparam logic [9:0] CURVE_ROM [TABLE_CAP] = '{
    10'd989, 10'd795, 10'd680, 10'd574, 10'd533, 10'd529, 10'd477, 10'd519,
    10'd452, 10'd503, 10'd442, 10'd435, 10'd423, 10'd398, 10'd436, 10'd392,
    10'd388, 10'd405, 10'd406, 10'd406, 10'd364, 10'd386, 10'd380, 10'd392,
    10'd374, 10'd391, 10'd367, 10'd374, 10'd358, 10'd347, 10'd374, 10'd365,
    10'd369, 10'd351, 10'd341, 10'd343, 10'd359, 10'd328, 10'd327, 10'd332,
    10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0,
    10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0,
    10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0
  };

  // decisions and partial results carried from the first to the second stage
  typedef struct packed {
    logic        rearm;
    logic        running;
    logic        homing;
    logic        adjust;
    logic        guard_zero;
    logic        hit;
    logic        grow;
    logic [9:0]  load;
    logic [23:0] period;
    logic [40:0] rhs;
    logic [20:0] q10;
  } mid_t;

endpackage

`default_nettype wire

>>> rtl/slsg_in_if.sv
// Tick channel of the stall load speed governor: one beat per control tick.
// Uses slsg_pkg for field widths.
`default_nettype none

interface slsg_in_if;
  logic                         valid;
  logic                         ready;
  logic                         motor_running;
  logic [slsg_pkg::PERIOD_W-1:0] period_us;
  logic [slsg_pkg::LOAD_W-1:0]   load_value;
  logic                         homing_mode;
  logic                         adjust_mode;
  logic                         rearm_guard;

  modport source (
    output valid, motor_running, period_us, load_value, homing_mode, adjust_mode,
           rearm_guard,
    input  ready
  );
  modport sink (
    input  valid, motor_running, period_us, load_value, homing_mode, adjust_mode,
           rearm_guard,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/slsg_out_if.sv
// Result channel of the stall load speed governor: one beat per tick.
// Uses slsg_pkg for field widths.
`default_nettype none

interface slsg_out_if;
  logic                         valid;
  logic                         ready;
  logic                         move_finished;
  logic                         stall_stop;
  logic                         period_update;
  logic [slsg_pkg::PERIOD_W-1:0] new_period_us;

  modport source (
    output valid, move_finished, stall_stop, period_update, new_period_us,
    input  ready
  );
  modport sink (
    input  valid, move_finished, stall_stop, period_update, new_period_us,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/slsg_cfg_if.sv
// Register write channel of the stall load speed governor.
// Uses slsg_pkg for the index type and data width.
`default_nettype none

interface slsg_cfg_if;
  logic                      valid;
  logic                      ready;
  slsg_pkg::cfg_index_t      index;
  logic [slsg_pkg::CFG_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/stall_load_speed_governor.sv
// Top level of the stall load speed governor: three-register pipeline.
// Depends on slsg_pkg, slsg_in_if, slsg_out_if and slsg_cfg_if.
//
// One tick is accepted per clock cycle while the result side takes results,
// and its result passes through the input register, the arithmetic register
// and the result register; a stall on the result side holds the pipeline.
// The guard counter is updated as a tick leaves the input register, so
// consecutive homing ticks need no spacing. The first stage
// compares the period against all table brackets in parallel and forms the
// slope times period product and the tenth of the period; the second stage
// does the stall compare and the lengthen or shorten with its limit.
// Register writes are taken every cycle and must only be made while idle.
`default_nettype none

module stall_load_speed_governor #(
  parameter int TABLE_POINTS = 40
) (
  input  wire logic   clk,
  input  wire logic   rst,
  slsg_in_if.sink     tick,
  slsg_out_if.source  result,
  slsg_cfg_if.sink    cfg
);

  logic [4:0]  guard_ticks;
  logic [15:0] threshold_slope;
  logic [23:0] threshold_offset;
  logic [15:0] max_period_us;
  logic [15:0] min_period_us;
  logic [4:0]  guard_count;
  logic [4:0]  guard_count_next;

  logic        v1, v2, v3;
  logic        rdy2, rdy3, adv1;

  logic        s1_running, s1_homing, s1_adjust, s1_rearm;
  logic [23:0] s1_period;
  logic [9:0]  s1_load;

  slsg_pkg::mid_t mid;
  slsg_pkg::mid_t mid_next;

  logic [TABLE_POINTS-1:0] hit;
  logic [TABLE_POINTS-1:0] curve_gt;
  logic [4:0]  guard_dec;
  logic [39:0] slope_prod;
  logic [48:0] recip_prod;

  logic [25:0] lhs;
  logic        stall;
  logic [24:0] ten_q;
  logic [24:0] r10_full;
  logic [3:0]  r10;
  logic        ge5;
  logic [3:0]  rem5;
  logic [21:0] ceil5;
  logic [24:0] grow_p;
  logic [23:0] shrink_p;

  logic        fin_next, stall_next, upd_next;
  logic [23:0] np_next;

  // configuration
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      guard_ticks      <= slsg_pkg::RST_GUARD_TICKS;
      threshold_slope  <= slsg_pkg::RST_THRESHOLD_SLOPE;
      threshold_offset <= slsg_pkg::RST_THRESHOLD_OFFSET;
      max_period_us    <= slsg_pkg::RST_MAX_PERIOD;
      min_period_us    <= slsg_pkg::RST_MIN_PERIOD;
    end else if (cfg.valid) begin
      case (cfg.index)
        slsg_pkg::CFG_GUARD_TICKS:      guard_ticks      <= cfg.data[4:0];
        slsg_pkg::CFG_THRESHOLD_SLOPE:  threshold_slope  <= cfg.data[15:0];
        slsg_pkg::CFG_THRESHOLD_OFFSET: threshold_offset <= cfg.data[23:0];
        slsg_pkg::CFG_MAX_PERIOD:       max_period_us    <= cfg.data[15:0];
        slsg_pkg::CFG_MIN_PERIOD:       min_period_us    <= cfg.data[15:0];
        default: ;
      endcase
    end
  end

  // pipeline flow
  assign rdy3       = !v3 || result.ready;
  assign rdy2       = !v2 || rdy3;
  assign adv1       = v1 && rdy2;
  assign tick.ready = !v1 || rdy2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (tick.ready) v1 <= tick.valid;
      if (rdy2)       v2 <= v1;
      if (rdy3)       v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.ready && tick.valid) begin
      s1_running <= tick.motor_running;
      s1_period  <= tick.period_us;
      s1_load    <= tick.load_value;
      s1_homing  <= tick.homing_mode;
      s1_adjust  <= tick.adjust_mode;
      s1_rearm   <= tick.rearm_guard;
    end
  end

  // guard counter
  assign guard_dec = (guard_count != 5'd0) ? guard_count - 5'd1 : 5'd0;

  always_comb begin
    guard_count_next = guard_count;
    if (adv1) begin
      if (s1_rearm) begin
        guard_count_next = guard_ticks;
      end else if (s1_running && s1_homing) begin
        guard_count_next = guard_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      guard_count <= slsg_pkg::RST_GUARD_TICKS;
    end else begin
      guard_count <= guard_count_next;
    end
  end

  // first stage: brackets, products
  always_comb begin
    for (int i = 0; i < TABLE_POINTS; i++) begin
      hit[i] = (24'(slsg_pkg::PERIOD_ROM[i]) >= s1_period) &&
               ((i == TABLE_POINTS - 1) ? (s1_period != 24'd0)
                                        : (24'(slsg_pkg::PERIOD_NEXT[i]) < s1_period));
      if (i == 0) begin
        hit[i] = hit[i] || (s1_period >= 24'(slsg_pkg::PERIOD_ROM[0]));
      end
      curve_gt[i] = slsg_pkg::CURVE_ROM[i] > s1_load;
    end
  end

  assign slope_prod = 40'(threshold_slope) * 40'(s1_period);
  assign recip_prod = 49'(s1_period) * 49'(slsg_pkg::RECIP10);

  always_comb begin
    mid_next.rearm      = s1_rearm;
    mid_next.running    = s1_running;
    mid_next.homing     = s1_homing;
    mid_next.adjust     = s1_adjust;
    mid_next.guard_zero = (guard_dec == 5'd0);
    mid_next.hit        = |hit;
    mid_next.grow       = |(hit & curve_gt);
    mid_next.load       = s1_load;
    mid_next.period     = s1_period;
    mid_next.rhs        = 41'(slope_prod) + 41'(threshold_offset);
    mid_next.q10        = recip_prod[48:slsg_pkg::RECIP10_SHIFT];
  end

  always_ff @(posedge clk) begin
    if (rdy2) mid <= mid_next;
  end

  // second stage: stall test and new period
  assign lhs   = {mid.load, 16'd0};
  assign stall = mid.homing && mid.guard_zero && (41'(lhs) < mid.rhs);

  assign ten_q    = {1'b0, mid.q10, 3'd0} + {3'd0, mid.q10, 1'b0};
  assign r10_full = {1'b0, mid.period} - ten_q;
  assign r10      = r10_full[3:0];
  assign ge5      = r10 >= 4'd5;
  assign rem5     = ge5 ? r10 - 4'd5 : r10;
  assign ceil5    = {mid.q10, 1'b0} + 22'(ge5) + 22'(rem5 != 4'd0);

  always_comb begin
    grow_p = {1'b0, mid.period} + 25'(mid.q10);
    if (grow_p > 25'(max_period_us)) grow_p = 25'(max_period_us);
    shrink_p = mid.period - 24'(ceil5);
    if (shrink_p < 24'(min_period_us)) shrink_p = 24'(min_period_us);
  end

  always_comb begin
    fin_next   = 1'b0;
    stall_next = 1'b0;
    upd_next   = 1'b0;
    np_next    = 24'd0;
    if (mid.rearm) begin
      fin_next = 1'b0;
    end else if (!mid.running) begin
      fin_next = 1'b1;
    end else if (stall) begin
      fin_next   = 1'b1;
      stall_next = 1'b1;
    end else if (mid.adjust && mid.hit) begin
      upd_next = 1'b1;
      np_next  = mid.grow ? grow_p[23:0] : shrink_p;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      result.move_finished <= fin_next;
      result.stall_stop    <= stall_next;
      result.period_update <= upd_next;
      result.new_period_us <= np_next;
    end
  end

  assign result.valid = v3;

  // checks
  a_stall_finishes: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.stall_stop |-> result.move_finished)
    else $error("stall stop without move finished");

  a_update_excl: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.move_finished && result.period_update))
    else $error("period update on a finished move");

  a_idle_period_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.period_update |-> result.new_period_us == 24'd0)
    else $error("new period without update");

  a_guard_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> guard_count == guard_ticks)
    else $error("guard counter not loaded at reset");

endmodule

`default_nettype wire
